// ===== rtl/bcct_pkg.sv =====
// Shared types and constants for the box/circle collision test core.
// No dependencies.
package bcct_pkg;

	localparam logic OBJ_BOX    = 1'b0;
	localparam logic OBJ_CIRCLE = 1'b1;

	// Per-request decision flags carried down the pipeline
	typedef struct packed {
		logic overlap;   // strict bounding-box overlap on both axes
		logic both_box;  // box against box
		logic span;      // box/circle pair, circle centre within a box span
	} bcct_flags_t;

endpackage

// ===== rtl/bcct_if.sv =====
// Channel interfaces of the collision test core: object pair in, hit flag out.
// Depends on nothing.
interface bcct_pair_if #(parameter int COORD_BITS = 16);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] a_x;
	logic signed [COORD_BITS-1:0] a_y;
	logic        [COORD_BITS-2:0] a_w;
	logic        [COORD_BITS-2:0] a_h;
	logic                         a_shape;
	logic signed [COORD_BITS-1:0] b_x;
	logic signed [COORD_BITS-1:0] b_y;
	logic        [COORD_BITS-2:0] b_w;
	logic        [COORD_BITS-2:0] b_h;
	logic                         b_shape;

	modport source(output valid, a_x, a_y, a_w, a_h, a_shape, b_x, b_y, b_w, b_h, b_shape,
		input ready);
	modport sink(input valid, a_x, a_y, a_w, a_h, a_shape, b_x, b_y, b_w, b_h, b_shape,
		output ready);
endinterface

interface bcct_hit_if;
	logic valid;
	logic ready;
	logic hit;

	modport source(output valid, hit, input ready);
	modport sink(input valid, hit, output ready);
endinterface

// ===== rtl/bcct_geom.sv =====
// Geometry stage: role selection, doubled centre distances, overlap and span tests,
// and the operands of the squaring stage. Depends on bcct_pkg.
module bcct_geom #(
	parameter int W = 16
) (
	input  logic signed [W-1:0]   a_x,
	input  logic signed [W-1:0]   a_y,
	input  logic        [W-2:0]   a_w,
	input  logic        [W-2:0]   a_h,
	input  logic                  a_shape,
	input  logic signed [W-1:0]   b_x,
	input  logic signed [W-1:0]   b_y,
	input  logic        [W-2:0]   b_w,
	input  logic        [W-2:0]   b_h,
	input  logic                  b_shape,
	output bcct_pkg::bcct_flags_t flags,
	output logic signed [W+2:0]   m0,
	output logic signed [W+2:0]   m1,
	output logic signed [W+2:0]   m2,
	output logic signed [W+2:0]   m3,
	output logic        [W-1:0]   m4
);
	localparam int E = W + 3;

	logic                swap;
	logic                bb;
	logic                cc;
	logic signed [W-1:0] px, py, qx, qy;
	logic        [W-2:0] pw, ph, qw, qh;
	logic        [W-2:0] pmin, qmin;
	logic signed [E-1:0] dx1, dy1, dxc, dyc;
	logic signed [E-1:0] pwe, phe, qwe, qhe, sw, sh;
	logic signed [E-1:0] dxl, dxr, dyt, dyb;
	logic                xspan, yspan;

	assign bb   = (a_shape == bcct_pkg::OBJ_BOX) && (b_shape == bcct_pkg::OBJ_BOX);
	assign cc   = (a_shape == bcct_pkg::OBJ_CIRCLE) && (b_shape == bcct_pkg::OBJ_CIRCLE);
	// put the box in slot p
	assign swap = (a_shape == bcct_pkg::OBJ_CIRCLE) && (b_shape == bcct_pkg::OBJ_BOX);

	assign px = swap ? b_x : a_x;
	assign py = swap ? b_y : a_y;
	assign pw = swap ? b_w : a_w;
	assign ph = swap ? b_h : a_h;
	assign qx = swap ? a_x : b_x;
	assign qy = swap ? a_y : b_y;
	assign qw = swap ? a_w : b_w;
	assign qh = swap ? a_h : b_h;

	assign dx1 = E'(qx) - E'(px);
	assign dy1 = E'(qy) - E'(py);
	assign dxc = dx1 <<< 1;
	assign dyc = dy1 <<< 1;

	assign pwe = signed'(E'(pw));
	assign phe = signed'(E'(ph));
	assign qwe = signed'(E'(qw));
	assign qhe = signed'(E'(qh));
	assign sw  = pwe + qwe;
	assign sh  = phe + qhe;

	assign flags.overlap  = (dxc < sw) && (dxc > -sw) && (dyc < sh) && (dyc > -sh);
	assign flags.both_box = bb;

	assign xspan      = (dxc >= -pwe) && (dxc <= pwe);
	assign yspan      = (dyc >= -phe) && (dyc <= phe);
	assign flags.span = !bb && !cc && (xspan || yspan);

	// corner offsets from the circle centre
	assign dxl = -dxc - pwe;
	assign dxr = pwe - dxc;
	assign dyt = -dyc - phe;
	assign dyb = phe - dyc;

	assign pmin = (pw < ph) ? pw : ph;
	assign qmin = (qw < qh) ? qw : qh;

	// circle pair: every corner pairing reduces to the centre distance
	assign m0 = cc ? dxc : dxl;
	assign m1 = cc ? dxc : dxr;
	assign m2 = cc ? dyc : dyt;
	assign m3 = cc ? dyc : dyb;
	assign m4 = cc ? (W'(pmin) + W'(qmin)) : W'(qmin);

endmodule

// ===== rtl/bcct_sq.sv =====
// Squaring stage: five parallel squares of the geometry operands.
// No dependencies; the flags bypass it in the caller.
module bcct_sq #(
	parameter int W = 16
) (
	input  logic signed [W+2:0]    m0,
	input  logic signed [W+2:0]    m1,
	input  logic signed [W+2:0]    m2,
	input  logic signed [W+2:0]    m3,
	input  logic        [W-1:0]    m4,
	output logic        [2*W+4:0]  sq0,
	output logic        [2*W+4:0]  sq1,
	output logic        [2*W+4:0]  sq2,
	output logic        [2*W+4:0]  sq3,
	output logic        [2*W-1:0]  sq4
);
	localparam int E = W + 3;

	logic signed [2*E-1:0] p0, p1, p2, p3;

	assign p0 = m0 * m0;
	assign p1 = m1 * m1;
	assign p2 = m2 * m2;
	assign p3 = m3 * m3;

	// squares are non-negative: drop the sign bit
	assign sq0 = p0[2*E-2:0];
	assign sq1 = p1[2*E-2:0];
	assign sq2 = p2[2*E-2:0];
	assign sq3 = p3[2*E-2:0];
	assign sq4 = m4 * m4;

endmodule

// ===== rtl/bcct_decide.sv =====
// Decision stage: corner/centre distance compares and the final hit flag.
// Depends on bcct_pkg.
module bcct_decide #(
	parameter int W = 16
) (
	input  bcct_pkg::bcct_flags_t flags,
	input  logic [2*W+4:0]        sq0,
	input  logic [2*W+4:0]        sq1,
	input  logic [2*W+4:0]        sq2,
	input  logic [2*W+4:0]        sq3,
	input  logic [2*W-1:0]        sq4,
	output logic                  hit
);
	localparam int S = 2 * W + 6;

	logic [S-1:0] lim;
	logic [S-1:0] d_lt, d_rt, d_lb, d_rb;
	logic         corner;

	assign lim  = S'(sq4);
	assign d_lt = S'(sq0) + S'(sq2);
	assign d_rt = S'(sq1) + S'(sq2);
	assign d_lb = S'(sq0) + S'(sq3);
	assign d_rb = S'(sq1) + S'(sq3);

	assign corner = (d_lt < lim) || (d_rt < lim) || (d_lb < lim) || (d_rb < lim);
	assign hit    = flags.overlap && (flags.both_box || flags.span || corner);

endmodule

// ===== rtl/box_circle_collision_test_core.sv =====
// Box/circle collision test core: one object pair per request, one hit flag back.
// Depends on bcct_pkg, bcct_if, bcct_geom, bcct_sq, bcct_decide.
//
// Takes one object pair per clock while pair.ready is high; the accepting edge loads
// the input register, then the geometry, square and result registers load in order.
// Throughput is one request per cycle unless the receiver stalls; each stage holds
// its request while the next is full, so pair.ready drops only when all four
// registers are occupied and the result is not taken. The interface COORD_BITS
// must match the core parameter.
module box_circle_collision_test_core #(
	parameter int COORD_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	bcct_pair_if.sink     pair,
	bcct_hit_if.source    result
);
	localparam int W = COORD_BITS;
	localparam int E = W + 3;

	// stage 1: input register
	logic                  v_s1;
	logic signed [W-1:0]   ax_s1, ay_s1, bx_s1, by_s1;
	logic        [W-2:0]   aw_s1, ah_s1, bw_s1, bh_s1;
	logic                  ashape_s1, bshape_s1;

	// stage 2: geometry register
	logic                  v_s2;
	bcct_pkg::bcct_flags_t flags_c, flags_s2;
	logic signed [E-1:0]   m0_c, m1_c, m2_c, m3_c;
	logic signed [E-1:0]   m0_s2, m1_s2, m2_s2, m3_s2;
	logic        [W-1:0]   m4_c, m4_s2;

	// stage 3: square register
	logic                  v_s3;
	bcct_pkg::bcct_flags_t flags_s3;
	logic        [2*E-2:0] sq0_c, sq1_c, sq2_c, sq3_c;
	logic        [2*E-2:0] sq0_s3, sq1_s3, sq2_s3, sq3_s3;
	logic        [2*W-1:0] sq4_c, sq4_s3;

	// result register
	logic                  out_v_q;
	logic                  hit_c, hit_q;

	logic                  ld_o, ld3, ld2, ld1;

	assign ld_o = !out_v_q || result.ready;
	assign ld3  = !v_s3 || ld_o;
	assign ld2  = !v_s2 || ld3;
	assign ld1  = !v_s1 || ld2;

	assign pair.ready   = ld1;
	assign result.valid = out_v_q;
	assign result.hit   = hit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (ld1) v_s1 <= pair.valid;
			if (ld2) v_s2 <= v_s1;
			if (ld3) v_s3 <= v_s2;
			if (ld_o) out_v_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ld1) begin
			ax_s1     <= W'(pair.a_x);
			ay_s1     <= W'(pair.a_y);
			aw_s1     <= (W-1)'(pair.a_w);
			ah_s1     <= (W-1)'(pair.a_h);
			ashape_s1 <= pair.a_shape;
			bx_s1     <= W'(pair.b_x);
			by_s1     <= W'(pair.b_y);
			bw_s1     <= (W-1)'(pair.b_w);
			bh_s1     <= (W-1)'(pair.b_h);
			bshape_s1 <= pair.b_shape;
		end
		if (ld2) begin
			flags_s2 <= flags_c;
			m0_s2    <= m0_c;
			m1_s2    <= m1_c;
			m2_s2    <= m2_c;
			m3_s2    <= m3_c;
			m4_s2    <= m4_c;
		end
		if (ld3) begin
			flags_s3 <= flags_s2;
			sq0_s3   <= sq0_c;
			sq1_s3   <= sq1_c;
			sq2_s3   <= sq2_c;
			sq3_s3   <= sq3_c;
			sq4_s3   <= sq4_c;
		end
		if (ld_o) hit_q <= hit_c;
	end

	bcct_geom #(.W(W)) u_geom (
		.a_x(ax_s1), .a_y(ay_s1), .a_w(aw_s1), .a_h(ah_s1), .a_shape(ashape_s1),
		.b_x(bx_s1), .b_y(by_s1), .b_w(bw_s1), .b_h(bh_s1), .b_shape(bshape_s1),
		.flags(flags_c),
		.m0(m0_c), .m1(m1_c), .m2(m2_c), .m3(m3_c), .m4(m4_c)
	);

	bcct_sq #(.W(W)) u_sq (
		.m0(m0_s2), .m1(m1_s2), .m2(m2_s2), .m3(m3_s2), .m4(m4_s2),
		.sq0(sq0_c), .sq1(sq1_c), .sq2(sq2_c), .sq3(sq3_c), .sq4(sq4_c)
	);

	bcct_decide #(.W(W)) u_decide (
		.flags(flags_s3),
		.sq0(sq0_s3), .sq1(sq1_s3), .sq2(sq2_s3), .sq3(sq3_s3), .sq4(sq4_s3),
		.hit(hit_c)
	);

	a_ready_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!pair.ready |-> (v_s1 && v_s2 && v_s3 && out_v_q && !result.ready))
		else $error("input stalled while the pipeline has room");

	a_no_overlap_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && ld_o && !flags_s3.overlap) |=> !result.hit)
		else $error("hit reported without box overlap");

	a_box_pair_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && ld_o && flags_s3.overlap && flags_s3.both_box) |=> result.hit)
		else $error("overlapping boxes not reported as hit");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.ready && !v_s3) |=> !result.valid)
		else $error("result repeated after drain");

endmodule

// ===== tb/box_circle_collision_test_core_tb.sv =====
// Testbench for box_circle_collision_test_core: directed object pairs, then random pairs,
// each hit flag checked against its listed value or an in-bench prediction of the rules.
// Depends on bcct_pkg, bcct_if and the core RTL.
module box_circle_collision_test_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CB          = 16;
	localparam int CYCLE_LIMIT = 200000;
	localparam int BURST_LEN   = 80;

	typedef struct packed {
		logic signed [CB-1:0] ax;
		logic signed [CB-1:0] ay;
		logic        [CB-2:0] aw;
		logic        [CB-2:0] ah;
		logic                 ash;
		logic signed [CB-1:0] bx;
		logic signed [CB-1:0] by;
		logic        [CB-2:0] bw;
		logic        [CB-2:0] bh;
		logic                 bsh;
	} pair_t;

	typedef struct packed {
		pair_t p;
		logic  typed;
		logic  hit;
	} dir_row_t;

	typedef struct {
		longint cx;
		longint cy;
		longint w;
		longint h;
		logic   round;
	} body_t;

	logic clk = 1'b0;
	logic arst_n;

	bcct_pair_if #(.COORD_BITS(CB)) pair_ch ();
	bcct_hit_if hit_ch ();

	box_circle_collision_test_core #(.COORD_BITS(CB)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pair   (pair_ch),
		.result (hit_ch)
	);

	always #6 clk = ~clk;

	logic hit_exp_q [$];
	int   send_idle_pct;
	int   recv_stall_pct;
	bit   stall_burst_req;
	int   burst_left;
	int   err_count;
	int   cycle_count;

	dir_row_t dir_rows [0:15] = '{
		'{'{'h0000, 'h0000, 'h0000, 'h0000, bcct_pkg::OBJ_BOX,
			'h0000, 'h0000, 'h0000, 'h0000, bcct_pkg::OBJ_BOX}, 1'b1, 1'b0},
		'{'{'h0000, 'h0000, 'h7fff, 'h7fff, bcct_pkg::OBJ_BOX,
			'h0000, 'h0000, 'h7fff, 'h7fff, bcct_pkg::OBJ_BOX}, 1'b1, 1'b1},
		'{'{'h7fff, 'h7fff, 'h7fff, 'h7fff, bcct_pkg::OBJ_BOX,
			'h8000, 'h8000, 'h7fff, 'h7fff, bcct_pkg::OBJ_BOX}, 1'b1, 1'b0},
		'{'{'h8000, 'h8000, 'h7fff, 'h7fff, bcct_pkg::OBJ_CIRCLE,
			'h8000, 'h8000, 'h7fff, 'h7fff, bcct_pkg::OBJ_CIRCLE}, 1'b1, 1'b1},
		'{'{'h7fff, 'h7fff, 'h7fff, 'h7fff, bcct_pkg::OBJ_CIRCLE,
			'h7fff, 'h7fff, 'h7fff, 'h7fff, bcct_pkg::OBJ_BOX}, 1'b1, 1'b1},
		'{'{'h0000, 'h0000, 'h0000, 'h0040, bcct_pkg::OBJ_BOX,
			'h0000, 'h0000, 'h0000, 'h0040, bcct_pkg::OBJ_BOX}, 1'b1, 1'b0},
		'{'{'h0064, 'h0064, 'h0000, 'h0040, bcct_pkg::OBJ_BOX,
			'h0064, 'h0064, 'h0028, 'h0028, bcct_pkg::OBJ_BOX}, 1'b0, 1'b0},
		'{'{'h0000, 'h0000, 'h0040, 'h0020, bcct_pkg::OBJ_CIRCLE,
			'h0020, 'h0000, 'h0040, 'h0020, bcct_pkg::OBJ_CIRCLE}, 1'b0, 1'b0},
		'{'{'h0000, 'h0000, 'h0040, 'h0020, bcct_pkg::OBJ_CIRCLE,
			'h001f, 'h0000, 'h0040, 'h0020, bcct_pkg::OBJ_CIRCLE}, 1'b0, 1'b0},
		'{'{'h0000, 'h0000, 'h0020, 'h0020, bcct_pkg::OBJ_BOX,
			'h000a, 'h001e, 'h0020, 'h0020, bcct_pkg::OBJ_CIRCLE}, 1'b0, 1'b0},
		'{'{'h001e, 'h000a, 'h0020, 'h0030, bcct_pkg::OBJ_CIRCLE,
			'h0000, 'h0000, 'h0020, 'h0020, bcct_pkg::OBJ_BOX}, 1'b0, 1'b0},
		'{'{'h0000, 'h0000, 'h0020, 'h0020, bcct_pkg::OBJ_BOX,
			'h0014, 'h0014, 'h0020, 'h0020, bcct_pkg::OBJ_CIRCLE}, 1'b0, 1'b0},
		'{'{'h0000, 'h0000, 'h0020, 'h0020, bcct_pkg::OBJ_BOX,
			'h001e, 'h001e, 'h0020, 'h0020, bcct_pkg::OBJ_CIRCLE}, 1'b0, 1'b0},
		'{'{'h5555, 'haaaa, 'h2aaa, 'h5555, bcct_pkg::OBJ_CIRCLE,
			'haaaa, 'h5555, 'h5555, 'h2aaa, bcct_pkg::OBJ_BOX}, 1'b0, 1'b0},
		'{'{'h0000, 'h0000, 'h0020, 'h0020, bcct_pkg::OBJ_BOX,
			'h0020, 'h0000, 'h0020, 'h0020, bcct_pkg::OBJ_BOX}, 1'b1, 1'b0},
		'{'{'h000a, 'h000a, 'h0001, 'h0002, bcct_pkg::OBJ_CIRCLE,
			'h000a, 'h000a, 'h0003, 'h0001, bcct_pkg::OBJ_CIRCLE}, 1'b1, 1'b1}
	};

	function automatic body_t doubled(logic signed [CB-1:0] x, logic signed [CB-1:0] y,
		logic [CB-2:0] w, logic [CB-2:0] h, logic shape);
		body_t o;
		o.cx    = 2 * longint'(x);
		o.cy    = 2 * longint'(y);
		o.w     = longint'(w);
		o.h     = longint'(h);
		o.round = (shape == bcct_pkg::OBJ_CIRCLE);
		return o;
	endfunction

	function automatic logic corner_inside(body_t c, longint px, longint py);
		longint dx, dy, d;
		dx = px - c.cx;
		dy = py - c.cy;
		d  = (c.w < c.h) ? c.w : c.h;
		return (dx * dx + dy * dy) < (d * d);
	endfunction

	function automatic logic box_hits_circle(body_t b, body_t c);
		longint l, r, t, bo, gap;
		l  = b.cx - b.w;
		r  = b.cx + b.w;
		t  = b.cy - b.h;
		bo = b.cy + b.h;
		if (l <= c.cx && c.cx <= r) begin
			gap = c.cy - b.cy;
			return (b.h + c.h) > ((gap < 0) ? -gap : gap);
		end
		if (t <= c.cy && c.cy <= bo) begin
			gap = c.cx - b.cx;
			return (b.w + c.w) > ((gap < 0) ? -gap : gap);
		end
		return corner_inside(c, l, t) || corner_inside(c, r, t) ||
			corner_inside(c, l, bo) || corner_inside(c, r, bo);
	endfunction

	function automatic logic predict_hit(pair_t p);
		body_t  a, b;
		longint dx, dy, s;
		a = doubled(p.ax, p.ay, p.aw, p.ah, p.ash);
		b = doubled(p.bx, p.by, p.bw, p.bh, p.bsh);
		if (!((b.cx - b.w) < (a.cx + a.w) && (a.cx - a.w) < (b.cx + b.w) &&
			(b.cy - b.h) < (a.cy + a.h) && (a.cy - a.h) < (b.cy + b.h)))
			return 1'b0;
		if (!a.round && !b.round)
			return 1'b1;
		if (a.round && b.round) begin
			dx = a.cx - b.cx;
			dy = a.cy - b.cy;
			s  = ((a.w < a.h) ? a.w : a.h) + ((b.w < b.h) ? b.w : b.h);
			return (dx * dx + dy * dy) < (s * s);
		end
		if (a.round)
			return box_hits_circle(b, a);
		return box_hits_circle(a, b);
	endfunction

	function automatic pair_t make_pair();
		pair_t p;
		int    max_size;
		p.ax  = 16'($urandom);
		p.ay  = 16'($urandom);
		p.aw  = 15'($urandom);
		p.ah  = 15'($urandom);
		p.ash = 1'($urandom);
		p.bx  = 16'($urandom);
		p.by  = 16'($urandom);
		p.bw  = 15'($urandom);
		p.bh  = 15'($urandom);
		p.bsh = 1'($urandom);
		// most pairs sit close together with modest sizes so every rule gets exercised
		if ($urandom_range(99) < 75) begin
			max_size = ($urandom_range(9) == 0) ? 32767 : 640;
			p.bx = p.ax + 16'(int'($urandom_range(1280)) - 640);
			p.by = p.ay + 16'(int'($urandom_range(1280)) - 640);
			p.aw = 15'($urandom_range(max_size));
			p.ah = 15'($urandom_range(max_size));
			p.bw = 15'($urandom_range(max_size));
			p.bh = 15'($urandom_range(max_size));
			if ($urandom_range(19) == 0)
				p.aw = '0;
			if ($urandom_range(19) == 0)
				p.bh = '0;
		end
		return p;
	endfunction

	task automatic offer(pair_t p, logic typed, logic typed_hit);
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			pair_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		pair_ch.valid   <= 1'b1;
		pair_ch.a_x     <= p.ax;
		pair_ch.a_y     <= p.ay;
		pair_ch.a_w     <= p.aw;
		pair_ch.a_h     <= p.ah;
		pair_ch.a_shape <= p.ash;
		pair_ch.b_x     <= p.bx;
		pair_ch.b_y     <= p.by;
		pair_ch.b_w     <= p.bw;
		pair_ch.b_h     <= p.bh;
		pair_ch.b_shape <= p.bsh;
		do @(posedge clk); while (!pair_ch.ready);
		hit_exp_q.push_back(typed ? typed_hit : predict_hit(p));
	endtask

	task automatic drain();
		pair_ch.valid <= 1'b0;
		while (hit_exp_q.size() != 0)
			@(posedge clk);
	endtask

	// receiver: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (stall_burst_req) begin
			burst_left      = BURST_LEN;
			stall_burst_req = 1'b0;
		end
		if (burst_left != 0) begin
			burst_left--;
			hit_ch.ready <= 1'b0;
		end else begin
			hit_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && hit_ch.valid && hit_ch.ready) begin
			if (hit_exp_q.size() == 0) begin
				err_count++;
				if (err_count <= 10)
					$display("unexpected hit result %0b at %0t", hit_ch.hit, $realtime);
			end else if (hit_ch.hit !== hit_exp_q[0]) begin
				err_count++;
				if (err_count <= 10)
					$display("hit mismatch at %0t: expected %0b, got %0b",
						$realtime, hit_exp_q[0], hit_ch.hit);
				void'(hit_exp_q.pop_front());
			end else begin
				void'(hit_exp_q.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		arst_n          = 1'b0;
		pair_ch.valid   = 1'b0;
		pair_ch.a_x     = '0;
		pair_ch.a_y     = '0;
		pair_ch.a_w     = '0;
		pair_ch.a_h     = '0;
		pair_ch.a_shape = bcct_pkg::OBJ_BOX;
		pair_ch.b_x     = '0;
		pair_ch.b_y     = '0;
		pair_ch.b_w     = '0;
		pair_ch.b_h     = '0;
		pair_ch.b_shape = bcct_pkg::OBJ_BOX;
		send_idle_pct   = 0;
		recv_stall_pct  = 0;
		stall_burst_req = 1'b0;
		burst_left      = 0;
		err_count       = 0;
		cycle_count     = 0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			offer(dir_rows[i].p, dir_rows[i].typed, dir_rows[i].hit);
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
				default: begin send_idle_pct = 19; recv_stall_pct = 19; end
			endcase
			repeat (220)
				offer(make_pair(), 1'b0, 1'b0);
			drain();
		end

		// hold the receiver off while requests keep coming, so the pipeline fills
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		@(negedge clk);
		stall_burst_req = 1'b1;
		@(posedge clk);
		repeat (60)
			offer(make_pair(), 1'b0, 1'b0);
		drain();

		send_idle_pct  = 19;
		recv_stall_pct = 19;
		repeat (40)
			offer(make_pair(), 1'b0, 1'b0);
		drain();
		repeat (10) @(posedge clk);

		if (err_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/bcct_pkg.sv
rtl/bcct_if.sv
rtl/bcct_geom.sv
rtl/bcct_sq.sv
rtl/bcct_decide.sv
rtl/box_circle_collision_test_core.sv
tb/box_circle_collision_test_core_tb.sv
